// File: rtl/core/fwwt_pkg.sv
// ----------------------------------------------------------------------------
// fwwt_pkg
// Shared types and constants for the futex wait/wake table.
// ----------------------------------------------------------------------------
package fwwt_pkg;

  localparam int unsigned SLOTS_DEF = 32;
  localparam int unsigned WAITERS_DEF = 16;
  localparam int unsigned RESULT_CAP = 16;

  localparam logic [3:0] KIND_WAIT = 4'd0;
  localparam logic [3:0] KIND_WAKE = 4'd1;

  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_WAKE = 3'd2;
  localparam logic [2:0] ST_UNSUP = 3'd3;
  localparam logic [2:0] ST_TFULL = 3'd4;
  localparam logic [2:0] ST_QFULL = 3'd5;

  typedef struct packed {
    logic [3:0] kind;
    logic [31:0] word_address;
    logic signed [31:0] current_value;
    logic signed [31:0] operand_value;
    logic [15:0] thread_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [15:0] woken_thread;
    logic [4:0] woken_count;
    logic last;
  } out_word_t;

  // Front-to-back command, opcode already classified.
  typedef struct packed {
    logic tfull;
    logic is_wait;
    logic is_wake;
    logic match;
    logic [15:0] thread_id;
    logic signed [31:0] operand_value;
  } cmd_t;

endpackage

// File: rtl/core/fwwt_front.sv
// ----------------------------------------------------------------------------
// fwwt_front
// Accepts requests, scans the slot table one slot a cycle, claims free slots.
// ----------------------------------------------------------------------------
module fwwt_front #(
  parameter int unsigned SLOTS = fwwt_pkg::SLOTS_DEF,
  parameter int unsigned SW = $clog2(SLOTS)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fwwt_pkg::in_word_t in_word,
  output logic cmd_valid,
  input  logic cmd_full,
  output fwwt_pkg::cmd_t cmd,
  output logic [SW-1:0] cmd_slot,
  output logic cmd_fresh
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SCAN = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state;
  fwwt_pkg::in_word_t req;
  logic [SLOTS-1:0] used;
  logic [31:0] keys [SLOTS];
  logic [SW-1:0] idx;
  logic found;
  logic free_ok;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] hit_idx;
  logic fresh;

  assign in_stall = (state != F_IDLE);
  assign cmd_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      used <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            req <= in_word;
            idx <= '0;
            found <= 1'b0;
            free_ok <= 1'b0;
            state <= F_SCAN;
          end
        end
        F_SCAN: begin
          if (used[idx]) begin
            if (!found && keys[idx] == req.word_address) begin
              found <= 1'b1;
              hit_idx <= idx;
            end
          end else begin
            free_ok <= 1'b1;
            free_idx <= idx;
          end
          if (idx == SW'(SLOTS - 1)) begin
            state <= F_PUSH;
          end
          idx <= idx + 1'b1;
        end
        F_PUSH: begin
          if (!cmd_full) begin
            state <= F_IDLE;
            if (!found && free_ok) begin
              used[free_idx] <= 1'b1;
              keys[free_idx] <= req.word_address;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    fresh = !found;
    cmd.tfull = !found && !free_ok;
    cmd.is_wait = (req.kind == fwwt_pkg::KIND_WAIT);
    cmd.is_wake = (req.kind == fwwt_pkg::KIND_WAKE);
    cmd.match = (req.current_value == req.operand_value);
    cmd.thread_id = req.thread_id;
    cmd.operand_value = req.operand_value;
  end

  assign cmd_slot = found ? hit_idx : free_idx;
  assign cmd_fresh = fresh;

endmodule

// File: rtl/core/fwwt_queue.sv
// ----------------------------------------------------------------------------
// fwwt_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module fwwt_queue #(
  parameter int unsigned W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [W-1:0] din,
  output logic empty,
  input  logic pop,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem [2];
  logic wp;
  logic rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        mem[wp] <= din;
        wp <= ~wp;
      end
      if (pop && !empty) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// File: rtl/core/fwwt_back.sv
// ----------------------------------------------------------------------------
// fwwt_back
// Executes wait and wake commands on per-slot waiter rings.
// ----------------------------------------------------------------------------
module fwwt_back #(
  parameter int unsigned SLOTS = fwwt_pkg::SLOTS_DEF,
  parameter int unsigned WAITERS = fwwt_pkg::WAITERS_DEF,
  parameter int unsigned SW = $clog2(SLOTS),
  parameter int unsigned WW = (WAITERS > 1) ? $clog2(WAITERS) : 1,
  parameter int unsigned FW = $clog2(WAITERS + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_avail,
  output logic cmd_pop,
  input  fwwt_pkg::cmd_t cmd,
  input  logic [SW-1:0] cmd_slot,
  input  logic cmd_fresh,
  output logic out_valid,
  input  logic out_stall,
  output fwwt_pkg::out_word_t out_word
);

  localparam int unsigned AW = SW + WW;
  localparam int unsigned CW = $clog2(fwwt_pkg::RESULT_CAP + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_WAKE = 4'b0010,
    B_READ = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state;
  logic [15:0] ids [SLOTS * (2 ** WW)];
  logic [WW-1:0] head [SLOTS];
  logic [FW-1:0] fill [SLOTS];
  logic [SW-1:0] slot;
  logic [CW-1:0] want;
  logic [CW-1:0] done_cnt;
  logic [15:0] rd_data;
  logic [WW-1:0] cur_head;
  logic [FW-1:0] cur_fill;
  logic [WW-1:0] wpos;
  logic [CW-1:0] n;
  logic [CW-1:0] cnt_next;
  logic [2:0] idle_status;
  logic enq;
  logic wake_start;

  function automatic logic [WW-1:0] wrap(input logic [WW:0] v);
    logic [WW:0] r;
    r = (v >= (WW+1)'(WAITERS)) ? v - (WW+1)'(WAITERS) : v;
    return r[WW-1:0];
  endfunction

  assign cmd_pop = (state == B_IDLE) && cmd_avail && !(out_valid && out_stall);
  assign cur_head = cmd_fresh ? '0 : head[cmd_slot];
  assign cur_fill = cmd_fresh ? '0 : fill[cmd_slot];
  assign wpos = wrap({1'b0, cur_head} + (WW+1)'(cur_fill));
  assign cnt_next = done_cnt + 1'b1;
  assign wake_start = !cmd.tfull && !cmd.is_wait && cmd.is_wake && (n != '0);

  always_comb begin
    n = '0;
    if (!cmd.operand_value[31]) begin
      if (cmd.operand_value[30:0] >= 31'(fwwt_pkg::RESULT_CAP)) begin
        n = CW'(fwwt_pkg::RESULT_CAP);
      end else begin
        n = cmd.operand_value[CW-1:0];
      end
    end
    if (32'(cur_fill) < 32'(n)) begin
      n = CW'(cur_fill);
    end
  end

  always_comb begin
    idle_status = fwwt_pkg::ST_UNSUP;
    enq = 1'b0;
    if (cmd.tfull) begin
      idle_status = fwwt_pkg::ST_TFULL;
    end else if (cmd.is_wait) begin
      if (!cmd.match) begin
        idle_status = fwwt_pkg::ST_MISMATCH;
      end else if (32'(cur_fill) >= 32'(WAITERS)) begin
        idle_status = fwwt_pkg::ST_QFULL;
      end else begin
        idle_status = fwwt_pkg::ST_QUEUED;
        enq = 1'b1;
      end
    end else if (cmd.is_wake) begin
      idle_status = fwwt_pkg::ST_WAKE;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      rd_data <= ids[{slot, head[slot]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      case (state)
        B_IDLE: begin
          if (cmd_pop) begin
            if (wake_start) begin
              out_valid <= 1'b0;
              slot <= cmd_slot;
              want <= n;
              done_cnt <= '0;
              state <= B_READ;
            end else begin
              out_valid <= 1'b1;
              out_word <= '{status: idle_status, woken_thread: 16'd0,
                            woken_count: 5'd0, last: 1'b1};
            end
            if (!cmd.tfull && cmd_fresh) begin
              head[cmd_slot] <= '0;
            end
            if (enq) begin
              ids[AW'({cmd_slot, wpos})] <= cmd.thread_id;
              fill[cmd_slot] <= cur_fill + 1'b1;
            end else if (!cmd.tfull && cmd_fresh) begin
              fill[cmd_slot] <= '0;
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        B_READ: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          state <= B_WAKE;
        end
        B_WAKE: begin
          if (!(out_valid && out_stall)) begin
            out_valid <= 1'b1;
            out_word <= '{status: fwwt_pkg::ST_WAKE, woken_thread: rd_data,
                          woken_count: 5'(cnt_next), last: (cnt_next == want)};
            head[slot] <= wrap({1'b0, head[slot]} + 1'b1);
            fill[slot] <= fill[slot] - 1'b1;
            done_cnt <= cnt_next;
            state <= (cnt_next == want) ? B_IDLE : B_OUT;
          end
        end
        B_OUT: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          state <= B_READ;
        end
        default: begin
          out_valid <= 1'b0;
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/futex_wait_wake_table_unit.sv
// ----------------------------------------------------------------------------
// futex_wait_wake_table_unit
// Futex engine: slot table keyed by word address, FIFO of waiters per slot.
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_word  (fwwt_pkg::in_word_t)
//   out     | out | out_valid/out_stall| out_word (fwwt_pkg::out_word_t)
//
// Front scans the slot table one slot per cycle and stalls input until the request is queued.
// Back issues one result per request, or one result per woken thread for a wake.
// Synchronous reset clears slot valid bits, ring heads and fill counts.
// A two-entry queue lets the front scan while the back waits on out_stall.
// ----------------------------------------------------------------------------
module futex_wait_wake_table_unit #(
  parameter int unsigned SLOTS = fwwt_pkg::SLOTS_DEF,
  parameter int unsigned WAITERS_PER_SLOT = fwwt_pkg::WAITERS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  fwwt_pkg::in_word_t in_word,
  output logic out_valid,
  input  logic out_stall,
  output fwwt_pkg::out_word_t out_word
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned QW = $bits(fwwt_pkg::cmd_t) + SW + 1;

  fwwt_pkg::cmd_t f_cmd;
  fwwt_pkg::cmd_t b_cmd;
  logic [SW-1:0] f_slot;
  logic [SW-1:0] b_slot;
  logic f_fresh;
  logic b_fresh;
  logic f_valid;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic [QW-1:0] q_out;

  fwwt_front #(.SLOTS(SLOTS), .SW(SW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .cmd_valid(f_valid), .cmd_full(q_full), .cmd(f_cmd),
    .cmd_slot(f_slot), .cmd_fresh(f_fresh)
  );

  fwwt_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(f_valid), .full(q_full), .din({f_cmd, f_slot, f_fresh}),
    .empty(q_empty), .pop(q_pop), .dout(q_out)
  );

  assign {b_cmd, b_slot, b_fresh} = q_out;

  fwwt_back #(.SLOTS(SLOTS), .WAITERS(WAITERS_PER_SLOT), .SW(SW)) u_back (
    .clk(clk), .rst(rst),
    .cmd_avail(!q_empty), .cmd_pop(q_pop), .cmd(b_cmd),
    .cmd_slot(b_slot), .cmd_fresh(b_fresh),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

endmodule

// File: tb/futex_wait_wake_table_unit_tb.sv
// ----------------------------------------------------------------------------
// futex_wait_wake_table_unit_tb
// Self-checking bench: requests go in through a bursty sender, results come
// back through a receiver that stalls on its own pattern, and each result
// word is checked field by field against a behavioral futex table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module futex_wait_wake_table_unit_tb;

  localparam int NSLOT = 32;
  localparam int NWAIT = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  fwwt_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fwwt_pkg::out_word_t out_word;

  futex_wait_wake_table_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always #4 clk = ~clk;

  // behavioral table
  bit          tbl_used [NSLOT];
  logic [31:0] tbl_key [NSLOT];
  logic [15:0] tbl_ring [NSLOT][NWAIT];
  int          tbl_head [NSLOT];
  int          tbl_fill [NSLOT];

  fwwt_pkg::out_word_t result_q[$];
  int        errors = 0;
  int        sent = 0;
  int        results_seen = 0;
  int        hold_off = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  bit        gaps_on = 1'b1;
  logic [31:0] addr_pool [8];

  task automatic push_result(input logic [2:0] st, input logic [15:0] thd,
                             input logic [4:0] cnt, input logic lst);
    fwwt_pkg::out_word_t w;
    w.status = st;
    w.woken_thread = thd;
    w.woken_count = cnt;
    w.last = lst;
    result_q.push_back(w);
  endtask

  task automatic predict_futex(input fwwt_pkg::in_word_t r);
    int s;
    int fr;
    int n;
    int h;
    s = -1;
    fr = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_used[i]) begin
        if (tbl_key[i] == r.word_address && s < 0) s = i;
      end else begin
        fr = i;
      end
    end
    if (s < 0 && fr >= 0) begin
      s = fr;
      tbl_used[s] = 1'b1;
      tbl_key[s] = r.word_address;
      tbl_head[s] = 0;
      tbl_fill[s] = 0;
    end
    if (s < 0) begin
      push_result(fwwt_pkg::ST_TFULL, '0, '0, 1'b1);
    end else if (r.kind == fwwt_pkg::KIND_WAIT) begin
      if (r.current_value != r.operand_value) begin
        push_result(fwwt_pkg::ST_MISMATCH, '0, '0, 1'b1);
      end else if (tbl_fill[s] >= NWAIT) begin
        push_result(fwwt_pkg::ST_QFULL, '0, '0, 1'b1);
      end else begin
        tbl_ring[s][(tbl_head[s] + tbl_fill[s]) % NWAIT] = r.thread_id;
        tbl_fill[s]++;
        push_result(fwwt_pkg::ST_QUEUED, '0, '0, 1'b1);
      end
    end else if (r.kind == fwwt_pkg::KIND_WAKE) begin
      n = tbl_fill[s];
      if (r.operand_value < 0) n = 0;
      else if (r.operand_value < n) n = r.operand_value;
      if (n > fwwt_pkg::RESULT_CAP) n = fwwt_pkg::RESULT_CAP;
      if (n == 0) push_result(fwwt_pkg::ST_WAKE, '0, '0, 1'b1);
      for (int k = 0; k < n; k++) begin
        h = tbl_head[s];
        tbl_head[s] = (h + 1) % NWAIT;
        tbl_fill[s]--;
        push_result(fwwt_pkg::ST_WAKE, tbl_ring[s][h], 5'(k + 1), k + 1 == n);
      end
    end else begin
      push_result(fwwt_pkg::ST_UNSUP, '0, '0, 1'b1);
    end
  endtask

  task automatic send_request(input logic [3:0] kind, input logic [31:0] addr,
                              input logic [31:0] cur, input logic [31:0] opnd,
                              input logic [15:0] tid);
    fwwt_pkg::in_word_t r;
    r.kind = kind;
    r.word_address = addr;
    r.current_value = cur;
    r.operand_value = opnd;
    r.thread_id = tid;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_futex(r);
    sent++;
  endtask

  // receiver stall pattern plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 300;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= gaps_on ? ($urandom_range(0, 3) == 0) : 1'b0;
    end
  end

  always @(posedge clk) begin
    fwwt_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", out_word);
      end else begin
        e = result_q.pop_front();
        if (out_word.status !== e.status || out_word.woken_thread !== e.woken_thread ||
            out_word.woken_count !== e.woken_count || out_word.last !== e.last) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %p got %p", e, out_word);
        end
      end
    end
  end

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(fwwt_pkg::KIND_WAKE, 32'h0, 0, 5, 0);
    send_request(fwwt_pkg::KIND_WAIT, 32'h0, 7, 8, 1);
    send_request(fwwt_pkg::KIND_WAIT, 32'h0, 7, 7, 16'hFFFF);
    send_request(fwwt_pkg::KIND_WAIT, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 2);
    send_request(fwwt_pkg::KIND_WAIT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 3);
    send_request(4'hF, 32'h1234, 0, 0, 4);
    send_request(4'h2, 32'h0, 0, 0, 5);
    send_request(fwwt_pkg::KIND_WAKE, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0);
    send_request(fwwt_pkg::KIND_WAKE, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(fwwt_pkg::KIND_WAKE, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0);
    send_request(fwwt_pkg::KIND_WAKE, 32'h0, 0, 1, 0);
    wait_drain();
  endtask

  task automatic test_queue_full_and_cap();
    for (int i = 0; i < 17; i++)
      send_request(fwwt_pkg::KIND_WAIT, 32'hA5A5_0000, 3, 3, 16'(100 + i));
    send_request(fwwt_pkg::KIND_WAKE, 32'hA5A5_0000, 0, 32'd100, 0);
    wait_drain();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 10; i++) send_request(fwwt_pkg::KIND_WAIT, 32'hB00, 1, 1, 16'(i));
    send_request(fwwt_pkg::KIND_WAKE, 32'hB00, 0, 10, 0);
    wait_drain();
  endtask

  task automatic test_random(input int count);
    logic [31:0] v;
    logic [31:0] opnd;
    logic [3:0]  kind;
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) gaps_on = 1'b0;
      if (i == count * 3 / 4) gaps_on = 1'b1;
      v = $urandom;
      opnd = ($urandom_range(0, 3) != 0) ? v : $urandom;
      kind = ($urandom_range(0, 9) < 5) ? fwwt_pkg::KIND_WAIT : fwwt_pkg::KIND_WAKE;
      if ($urandom_range(0, 15) == 0) kind = 4'($urandom);
      if (kind == fwwt_pkg::KIND_WAKE) begin
        opnd = $urandom_range(0, 5);
        if ($urandom_range(0, 7) == 0) opnd = $urandom;
        if ($urandom_range(0, 15) == 0) opnd = 32'd20;
      end
      send_request(kind, ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)],
                   v, opnd, 16'($urandom));
    end
    wait_drain();
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 34; i++) send_request(4'($urandom_range(0, 2)), 32'hC000_0000 + i,
                                             0, 0, 16'(i));
    send_request(fwwt_pkg::KIND_WAKE, 32'hDEAD_BEEF, 0, 1, 0);
    wait_drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_queue_full_and_cap();
    test_backpressure();
    test_random(150);
    test_table_full();
    $display("covered %0d requests and %0d result words: wait, wake, unsupported,",
             sent, results_seen);
    $display("mismatch, queue full, wake cap, table full, long output hold-off");
    if (errors == 0 && result_q.size() == 0) begin
      $display("futex_wait_wake_table_unit_tb: PASS");
    end else begin
      $display("futex_wait_wake_table_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("futex_wait_wake_table_unit_tb: FAIL");
    $finish;
  end

endmodule
